// ===== sv/tpgm_pkg.sv =====
// ----------------------------------------------------------------------------
// tpgm_pkg
// Shared constants, codes and types of the two-path grid maximum collector.
// ----------------------------------------------------------------------------
`default_nettype none

package tpgm_pkg;

  localparam int GRID_MAX_DEF   = 16;
  localparam int VALUE_BITS_DEF = 16;

  localparam int SIZE_W  = 5;
  localparam int COORD_W = 5;
  localparam int VAL_W   = 16;
  localparam int TOTAL_W = 22;

  localparam logic [SIZE_W-1:0]  GRID_SIZE_RST = 5'd16;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX     = '1;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef enum logic [1:0] {
    CTL_CLEAR,
    CTL_IDLE,
    CTL_SWEEP,
    CTL_WAIT
  } ctl_state_t;

  typedef enum logic [1:0] {
    SW_IDLE,
    SW_RD0,
    SW_RD1,
    SW_CALC
  } sw_phase_t;

  typedef struct packed {
    logic               done;
    logic [TOTAL_W-1:0] total;
  } sw_stat_t;

endpackage

`default_nettype wire

// ===== sv/tpgm_if.sv =====
// ----------------------------------------------------------------------------
// tpgm_if
// Valid/ready channels of the collector: cell input, result output and the
// grid size register write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpgm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [tpgm_pkg::COORD_W-1:0] cell_row;
  logic [tpgm_pkg::COORD_W-1:0] cell_col;
  logic [tpgm_pkg::VAL_W-1:0]   cell_value;

  modport source (output valid, opcode, cell_row, cell_col, cell_value, input ready);
  modport sink (input valid, opcode, cell_row, cell_col, cell_value, output ready);
endinterface

interface tpgm_out_if;
  logic                         valid;
  logic                         ready;
  logic [tpgm_pkg::TOTAL_W-1:0] best_total;

  modport source (output valid, best_total, input ready);
  modport sink (input valid, best_total, output ready);
endinterface

interface tpgm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tpgm_pkg::SIZE_W-1:0] grid_size;

  modport source (output valid, grid_size, input ready);
  modport sink (input valid, grid_size, output ready);
endinterface

`default_nettype wire

// ===== sv/two_path_grid_max_collect_unit.sv =====
// ----------------------------------------------------------------------------
// two_path_grid_max_collect_unit
// Loads grid cells, then on a finish item computes the best total of two
// right/down paths with shared cells counted once, and clears the grid.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake      Payload
//   in_ch     in    valid/ready    opcode, cell_row, cell_col, cell_value
//   out_ch    out   valid/ready    best_total (one per finish item)
//   cfg       in    valid/ready    grid_size (always ready)
//
// Loads stream at one per cycle while the block is idle (in_ch.ready).
// A finish item steps every DP state through SW_RD0, SW_RD1 and SW_CALC,
// since the layer RAM has two read ports (2736 states at size 16), hands
// off the total and clears 2**(2*ceil(log2(GRID_MAX))) cells (256 by default).
// After reset the same clearing pass runs before the first item is taken.
// A stalled result waits in the output register while new loads are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module two_path_grid_max_collect_unit #(
  parameter int GRID_MAX   = tpgm_pkg::GRID_MAX_DEF,
  parameter int VALUE_BITS = tpgm_pkg::VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tpgm_in_if.sink    in_ch,
  tpgm_out_if.source out_ch,
  tpgm_cfg_if.sink   cfg
);

  import tpgm_pkg::*;

  localparam int IW     = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int NW     = $clog2(GRID_MAX + 1);
  localparam int GA     = 2 * IW;
  localparam int CELL_W = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;

  ctl_state_t ctl, ctl_next;

  logic [SIZE_W-1:0]  grid_size;
  logic [GA-1:0]      clear_idx;
  logic               out_valid;
  logic [TOTAL_W-1:0] out_total;

  logic [NW-1:0]      n_eff;
  logic               in_acc, load_ok, out_free, out_load, sw_start;
  logic [IW-1:0]      row_idx, col_idx;
  logic               grid_we;
  logic [GA-1:0]      grid_waddr, grid_raddr0, grid_raddr1;
  logic [CELL_W-1:0]  grid_wdata, grid_rdata0, grid_rdata1;
  sw_stat_t           sw_stat;

  always_comb begin
    if (grid_size == '0) begin
      n_eff = NW'(1);
    end else if ({1'b0, grid_size} > (SIZE_W+1)'(GRID_MAX)) begin
      n_eff = NW'(GRID_MAX);
    end else begin
      n_eff = NW'(grid_size);
    end
  end

  assign in_ch.ready = (ctl == CTL_IDLE);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign load_ok  = (in_ch.opcode == OP_LOAD) &&
                    (in_ch.cell_row != '0) && (in_ch.cell_col != '0) &&
                    ({1'b0, in_ch.cell_row} <= (COORD_W+1)'(GRID_MAX)) &&
                    ({1'b0, in_ch.cell_col} <= (COORD_W+1)'(GRID_MAX));
  assign row_idx  = IW'(in_ch.cell_row - COORD_W'(1));
  assign col_idx  = IW'(in_ch.cell_col - COORD_W'(1));
  assign out_free = !out_valid || out_ch.ready;

  always_comb begin
    ctl_next = ctl;
    unique case (ctl)
      CTL_CLEAR: begin
        if (&clear_idx) ctl_next = CTL_IDLE;
      end
      CTL_IDLE: begin
        if (in_acc && (in_ch.opcode == OP_FINISH)) ctl_next = CTL_SWEEP;
      end
      CTL_SWEEP: begin
        if (sw_stat.done) ctl_next = CTL_WAIT;
      end
      CTL_WAIT: begin
        if (out_free) ctl_next = CTL_CLEAR;
      end
      default: ctl_next = CTL_CLEAR;
    endcase
  end

  always_comb begin
    sw_start    = in_acc && (in_ch.opcode == OP_FINISH);
    out_load    = (ctl == CTL_WAIT) && out_free;
    if (ctl == CTL_CLEAR) begin
      grid_we    = 1'b1;
      grid_waddr = clear_idx;
      grid_wdata = '0;
    end else begin
      grid_we    = in_acc && load_ok;
      grid_waddr = {row_idx, col_idx};
      grid_wdata = in_ch.cell_value[CELL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl       <= CTL_CLEAR;
      clear_idx <= '0;
      out_valid <= 1'b0;
      grid_size <= GRID_SIZE_RST;
    end else begin
      ctl <= ctl_next;
      if (ctl == CTL_CLEAR) begin
        clear_idx <= clear_idx + GA'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid) begin
        grid_size <= cfg.grid_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_total <= sw_stat.total;
    end
  end

  assign cfg.ready         = 1'b1;
  assign out_ch.valid      = out_valid;
  assign out_ch.best_total = out_total;

  tpgm_ram #(
    .AW (GA),
    .DW (CELL_W)
  ) u_grid (
    .clk    (clk),
    .we     (grid_we),
    .waddr  (grid_waddr),
    .wdata  (grid_wdata),
    .raddr0 (grid_raddr0),
    .raddr1 (grid_raddr1),
    .rdata0 (grid_rdata0),
    .rdata1 (grid_rdata1)
  );

  tpgm_sweep #(
    .GRID_MAX   (GRID_MAX),
    .VALUE_BITS (VALUE_BITS)
  ) u_sweep (
    .clk         (clk),
    .rst         (rst),
    .start       (sw_start),
    .n           (n_eff),
    .grid_raddr0 (grid_raddr0),
    .grid_raddr1 (grid_raddr1),
    .grid_rdata0 (grid_rdata0),
    .grid_rdata1 (grid_rdata1),
    .stat        (sw_stat)
  );

  a_done_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sw_stat.done |-> ctl == CTL_SWEEP)
    else $error("sweep finished outside the sweep state");

  a_grid_quiet: assert property (@(posedge clk) disable iff (rst)
    (ctl == CTL_SWEEP || ctl == CTL_WAIT) |-> !grid_we)
    else $error("grid written while a sweep reads it");

  a_clear_wraps: assert property (@(posedge clk) disable iff (rst)
    (ctl == CTL_CLEAR) && (&clear_idx) |=> (ctl == CTL_IDLE) && (clear_idx == '0))
    else $error("clearing pass did not end cleanly");

endmodule

`default_nettype wire

// ===== sv/tpgm_ram.sv =====
// ----------------------------------------------------------------------------
// tpgm_ram
// Synchronous RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module tpgm_ram #(
  parameter int AW = 8,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [DW-1:0] rdata0,
  output logic [DW-1:0] rdata1
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

// ===== sv/tpgm_sweep.sv =====
// ----------------------------------------------------------------------------
// tpgm_sweep
// Dynamic programming sweep over anti-diagonals. Each state (a, b) holds the
// best total of two paths whose current rows are a and b. Two layers live in
// one RAM, selected by the parity of the diagonal.
// ----------------------------------------------------------------------------
`default_nettype none

module tpgm_sweep #(
  parameter int GRID_MAX   = tpgm_pkg::GRID_MAX_DEF,
  parameter int VALUE_BITS = tpgm_pkg::VALUE_BITS_DEF,
  localparam int IW     = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1,
  localparam int NW     = $clog2(GRID_MAX + 1),
  localparam int CELL_W = (VALUE_BITS < tpgm_pkg::VAL_W) ? VALUE_BITS : tpgm_pkg::VAL_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NW-1:0]        n,
  output logic [2*IW-1:0]      grid_raddr0,
  output logic [2*IW-1:0]      grid_raddr1,
  input  logic [CELL_W-1:0]    grid_rdata0,
  input  logic [CELL_W-1:0]    grid_rdata1,
  output tpgm_pkg::sw_stat_t   stat
);

  import tpgm_pkg::*;

  localparam int SW = $clog2(2 * GRID_MAX);
  localparam int LW = 1 + 2 * IW;

  sw_phase_t phase, phase_next;

  logic [SW-1:0]      s;
  logic [IW-1:0]      a, b;
  logic [TOTAL_W-1:0] best;
  logic [TOTAL_W-1:0] total;
  logic [CELL_W:0]    add;

  logic               lay_we;
  logic [LW-1:0]      lay_waddr, lay_raddr0, lay_raddr1;
  logic [TOTAL_W-1:0] lay_wdata, lay_rdata0, lay_rdata1;

  logic [SW-1:0]      n_s;
  logic [IW-1:0]      lo, hi, lo_nx;
  logic               last_diag, last_state;
  logic               a_same, a_up, b_same, b_up;
  logic               cur;
  logic [TOTAL_W-1:0] d0m, d1m, d2m, d3m, m01, m23, mbest;
  logic [CELL_W:0]    add_next;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] val;

  function automatic logic [SW-1:0] diag_lo(input logic [SW-1:0] sv, input logic [SW-1:0] nv);
    return (sv >= nv) ? (sv - nv + SW'(1)) : '0;
  endfunction

  function automatic logic [SW-1:0] diag_hi(input logic [SW-1:0] sv, input logic [SW-1:0] nv);
    return (sv < nv) ? sv : (nv - SW'(1));
  endfunction

  assign n_s        = SW'(n);
  assign lo         = IW'(diag_lo(s, n_s));
  assign hi         = IW'(diag_hi(s, n_s));
  assign lo_nx      = IW'(diag_lo(s + SW'(1), n_s));
  assign last_diag  = ({1'b0, s} == ((SW+1)'({n, 1'b0}) - (SW+1)'(2)));
  assign last_state = last_diag && (a == hi) && (b == hi);

  // A predecessor row is legal on the previous diagonal when staying put
  // does not run past the diagonal's start, or the row above, a - 1, is a grid row.
  assign a_same = (SW'(a) != s);
  assign a_up   = (a != '0);
  assign b_same = (SW'(b) != s);
  assign b_up   = (b != '0);

  assign cur = s[0];

  assign grid_raddr0 = {a, IW'(s - SW'(a))};
  assign grid_raddr1 = {b, IW'(s - SW'(b))};

  always_comb begin
    lay_raddr0 = {~cur, a, b};
    lay_raddr1 = {~cur, a - IW'(1), b};
    if (phase == SW_RD1) begin
      lay_raddr0 = {~cur, a, b - IW'(1)};
      lay_raddr1 = {~cur, a - IW'(1), b - IW'(1)};
    end
  end

  assign d0m   = (a_same && b_same) ? lay_rdata0 : '0;
  assign d1m   = (a_up && b_same) ? lay_rdata1 : '0;
  assign d2m   = (a_same && b_up) ? lay_rdata0 : '0;
  assign d3m   = (a_up && b_up) ? lay_rdata1 : '0;
  assign m01   = (d0m > d1m) ? d0m : d1m;
  assign m23   = (d2m > d3m) ? d2m : d3m;
  assign mbest = (best > m23) ? best : m23;

  // A cell shared by both paths is counted once.
  assign add_next = {1'b0, grid_rdata0} + ((a != b) ? {1'b0, grid_rdata1} : '0);
  assign sum      = {1'b0, mbest} + (TOTAL_W+1)'(add);
  assign val      = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  assign lay_waddr = {cur, a, b};
  assign lay_wdata = val;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      SW_IDLE: begin
        if (start) phase_next = SW_RD0;
      end
      SW_RD0:  phase_next = SW_RD1;
      SW_RD1:  phase_next = SW_CALC;
      SW_CALC: phase_next = last_state ? SW_IDLE : SW_RD0;
      default: phase_next = SW_IDLE;
    endcase
  end

  always_comb begin
    lay_we     = (phase == SW_CALC);
    stat.done  = (phase == SW_CALC) && last_state;
    stat.total = total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= SW_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      SW_IDLE: begin
        if (start) begin
          s <= '0;
          a <= '0;
          b <= '0;
        end
      end
      SW_RD1: begin
        best <= m01;
        add  <= add_next;
      end
      SW_CALC: begin
        if (last_state) begin
          total <= val;
        end else if (b != hi) begin
          b <= b + IW'(1);
        end else if (a != hi) begin
          a <= a + IW'(1);
          b <= lo;
        end else begin
          s <= s + SW'(1);
          a <= lo_nx;
          b <= lo_nx;
        end
      end
      default: ;
    endcase
  end

  tpgm_ram #(
    .AW (LW),
    .DW (TOTAL_W)
  ) u_layers (
    .clk    (clk),
    .we     (lay_we),
    .waddr  (lay_waddr),
    .wdata  (lay_wdata),
    .raddr0 (lay_raddr0),
    .raddr1 (lay_raddr1),
    .rdata0 (lay_rdata0),
    .rdata1 (lay_rdata1)
  );

  a_rows_on_diag: assert property (@(posedge clk) disable iff (rst)
    phase != SW_IDLE |-> (a >= lo) && (a <= hi) && (b >= lo) && (b <= hi))
    else $error("sweep row index left the current diagonal");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> phase == SW_IDLE)
    else $error("sweep started while busy");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> phase == SW_IDLE)
    else $error("sweep kept running after the final state");

endmodule

`default_nettype wire

// ===== test/tb_two_path_grid_max_collect_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_path_grid_max_collect_unit
// Self-checking bench for the two-path grid collector. Loads and finish items
// are applied through the valid/ready input channel. A local dynamic
// programming model predicts each best_total at the moment its finish item is
// accepted. A checker compares every result with the oldest prediction.
// Grid sizes are changed only once all results are in and the clearing pass
// is done.
// ----------------------------------------------------------------------------

module tb_two_path_grid_max_collect_unit;
  import tpgm_pkg::*;

  localparam int NMAX          = GRID_MAX_DEF;
  // Covers the hand-off of a total plus the clearing pass of the grid store.
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_ITEMS  = 1050;

  logic clk;
  logic rst;

  tpgm_in_if  in_ch ();
  tpgm_out_if out_ch ();
  tpgm_cfg_if cfg_ch ();

  two_path_grid_max_collect_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  logic [VAL_W-1:0]   grid_model [NMAX][NMAX];
  logic [SIZE_W-1:0]  size_model;
  logic [TOTAL_W-1:0] expected_totals [$];
  logic [TOTAL_W-1:0] oldest_total;
  int                 mismatch_count;
  int                 items_accepted;
  int                 finishes_accepted;
  int                 totals_checked;
  int                 hold_left;
  bit                 idle_off;
  bit [31:0]          sizes_written;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Row r lies on anti-diagonal d of an n x n grid.
  function automatic bit on_diag(int r, int d, int n);
    return r >= 0 && r < n && r <= d && (d - r) < n;
  endfunction

  function automatic int active_size();
    if (size_model == '0) return 1;
    if (size_model > NMAX) return NMAX;
    return int'(size_model);
  endfunction

  function automatic logic [TOTAL_W-1:0] predict_best_total();
    int              n, cur, nxt, d, a, b, pa, pb;
    longint unsigned layer [2][NMAX][NMAX];
    longint unsigned best, gain, total;
    n = active_size();
    cur = 0;
    layer[0][0][0] = grid_model[0][0];
    for (d = 1; d <= 2 * n - 2; d++) begin
      nxt = cur ^ 1;
      for (a = 0; a < n; a++) begin
        if (on_diag(a, d, n)) begin
          for (b = 0; b < n; b++) begin
            if (on_diag(b, d, n)) begin
              best = 0;
              for (pa = a - 1; pa <= a; pa++) begin
                for (pb = b - 1; pb <= b; pb++) begin
                  if (on_diag(pa, d - 1, n) && on_diag(pb, d - 1, n)) begin
                    if (layer[cur][pa][pb] > best) best = layer[cur][pa][pb];
                  end
                end
              end
              // A cell reached by both paths is collected only once.
              gain = grid_model[a][d - a];
              if (a != b) gain += grid_model[b][d - b];
              layer[nxt][a][b] = best + gain;
            end
          end
        end
      end
      cur = nxt;
    end
    total = layer[cur][n - 1][n - 1];
    if (total > TOTAL_MAX) total = TOTAL_MAX;
    return total[TOTAL_W-1:0];
  endfunction

  task automatic clear_grid_model();
    int r, c;
    for (r = 0; r < NMAX; r++) begin
      for (c = 0; c < NMAX; c++) grid_model[r][c] = '0;
    end
  endtask

  task automatic apply_item(input logic op, input logic [COORD_W-1:0] row,
                            input logic [COORD_W-1:0] col, input logic [VAL_W-1:0] val);
    items_accepted++;
    if (op == OP_LOAD) begin
      if (row >= 1 && row <= NMAX && col >= 1 && col <= NMAX) grid_model[row-1][col-1] = val;
    end else begin
      expected_totals.push_back(predict_best_total());
      finishes_accepted++;
      clear_grid_model();
    end
  endtask

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic send_item(input logic op, input logic [COORD_W-1:0] row,
                           input logic [COORD_W-1:0] col, input logic [VAL_W-1:0] val);
    int gap;
    @(negedge clk);
    if (!idle_off && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.cell_row   <= row;
    in_ch.cell_col   <= col;
    in_ch.cell_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    apply_item(op, row, col, val);
  endtask

  // Drops the input valid and waits until every total has come back and the
  // block has had time to clear its grid store.
  task automatic settle_after_results();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_grid_size(input logic [SIZE_W-1:0] size);
    settle_after_results();
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.grid_size <= size;
    do @(posedge clk); while (!cfg_ch.ready);
    size_model = size;
    sizes_written[size] = 1'b1;
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_grid_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return SIZE_W'(NMAX);
    if (roll < 6) return SIZE_W'($urandom_range(NMAX + 1, 31));
    if (roll < 8) return '0;
    if (roll < 12) return SIZE_W'(1);
    if (roll < 30) return SIZE_W'($urandom_range(7, 12));
    return SIZE_W'($urandom_range(2, 6));
  endfunction

  function automatic logic [VAL_W-1:0] pick_cell_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '1;
    if (roll < 25) return '0;
    return VAL_W'($urandom_range(0, 65535));
  endfunction

  // One grid: a burst of loads, mostly inside the current size, then a finish.
  task automatic send_random_grid();
    int                 n, nloads, k;
    logic [COORD_W-1:0] row, col;
    n = active_size();
    nloads = $urandom_range(1, (n * n + 3 < 30) ? n * n + 3 : 30);
    for (k = 0; k < nloads; k++) begin
      row = ($urandom_range(0, 99) < 88) ? COORD_W'($urandom_range(1, n))
                                         : COORD_W'($urandom_range(0, 31));
      col = ($urandom_range(0, 99) < 88) ? COORD_W'($urandom_range(1, n))
                                         : COORD_W'($urandom_range(0, 31));
      send_item(OP_LOAD, row, col, pick_cell_value());
    end
    send_item(OP_FINISH, COORD_W'($urandom_range(0, 31)), COORD_W'($urandom_range(0, 31)),
              VAL_W'($urandom_range(0, 65535)));
  endtask

  task automatic test_corner_loads();
    send_item(OP_LOAD, 5'd1, 5'd1, 16'hFFFF);
    send_item(OP_LOAD, 5'd16, 5'd16, 16'hFFFF);
    send_item(OP_LOAD, 5'd16, 5'd1, 16'h1234);
    send_item(OP_LOAD, 5'd1, 5'd16, 16'h8000);
    // The finish payload is ignored, so give it all ones.
    send_item(OP_FINISH, 5'd31, 5'd31, 16'hFFFF);
  endtask

  task automatic test_special_cases();
    // Size zero behaves as a single cell; a repeated load overwrites.
    write_grid_size('0);
    send_item(OP_LOAD, 5'd1, 5'd1, 16'd7);
    send_item(OP_LOAD, 5'd1, 5'd1, 16'd9);
    send_item(OP_LOAD, 5'd0, 5'd1, 16'hFFFF);
    send_item(OP_LOAD, 5'd1, 5'd0, 16'hFFFF);
    send_item(OP_LOAD, 5'd31, 5'd31, 16'hFFFF);
    send_item(OP_LOAD, 5'd17, 5'd2, 16'hAAAA);
    send_item(OP_FINISH, 5'd0, 5'd0, 16'h0000);
    // A cell outside the active size is stored but must not count.
    write_grid_size(5'd3);
    send_item(OP_LOAD, 5'd5, 5'd5, 16'd100);
    send_item(OP_LOAD, 5'd2, 5'd2, 16'd50);
    send_item(OP_LOAD, 5'd3, 5'd3, 16'd1);
    send_item(OP_FINISH, 5'd2, 5'd2, 16'h5555);
    // An oversized setting clamps to the full grid, which must now be empty.
    write_grid_size(5'd31);
    send_item(OP_FINISH, 5'd16, 5'd16, 16'h0001);
    // Two paths split around a 2 x 2 grid and share both corners.
    write_grid_size(5'd2);
    send_item(OP_LOAD, 5'd1, 5'd2, 16'd10);
    send_item(OP_LOAD, 5'd2, 5'd1, 16'd20);
    send_item(OP_LOAD, 5'd2, 5'd2, 16'h5555);
    send_item(OP_FINISH, 5'd1, 5'd1, 16'd0);
  endtask

  // The result side stops for a long stretch while grids keep arriving, so a
  // total waits in the output register and the input channel backs up.
  task automatic test_output_hold();
    write_grid_size(5'd4);
    hold_left = 2500;
    repeat (3) send_random_grid();
    settle_after_results();
  endtask

  task automatic test_random_grids();
    int run, start_items;
    start_items = items_accepted;
    for (run = 0; items_accepted - start_items < RANDOM_ITEMS; run++) begin
      idle_off = (run >= 20 && run < 32);
      if (run == 0 || $urandom_range(0, 99) < 60) write_grid_size(pick_grid_size());
      send_random_grid();
    end
    idle_off = 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!idle_off && $urandom_range(0, 99) < 25) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_totals.size() == 0) begin
        report_mismatch("best_total with no finish pending", 0, out_ch.best_total);
      end else begin
        oldest_total = expected_totals.pop_front();
        totals_checked++;
        if (out_ch.best_total !== oldest_total)
          report_mismatch("best_total", oldest_total, out_ch.best_total);
      end
    end
  end

  initial begin
    #80_000_000;
    $display("Timed out waiting for the block to finish");
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_LOAD;
    in_ch.cell_row    = '0;
    in_ch.cell_col    = '0;
    in_ch.cell_value  = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.grid_size  = GRID_SIZE_RST;
    size_model        = GRID_SIZE_RST;
    mismatch_count    = 0;
    items_accepted    = 0;
    finishes_accepted = 0;
    totals_checked    = 0;
    hold_left         = 0;
    idle_off          = 1'b0;
    sizes_written     = '0;
    clear_grid_model();
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_corner_loads();
    test_special_cases();
    test_output_hold();
    test_random_grids();
    settle_after_results();

    $display("Accepted %0d items, %0d of them finish items; checked %0d totals.",
             items_accepted, finishes_accepted, totals_checked);
    $display("Grid size values written (one bit per value): %b", sizes_written);
    if (mismatch_count == 0 && expected_totals.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
